@@ rtl/core/blfu_pkg.sv @@
// blfu_pkg: shared constants of the lowest-unused-value finder
// used by the channel interfaces and the top level; depends on nothing
`default_nettype none

package blfu_pkg;

  // width of the value fields on both channels
  localparam int VAL_W = 16;

  // fraction bits of the reciprocal used to split a value into word and bit
  localparam int DIV_SHIFT = 24;

  // item kinds on the input channel
  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_FIND   = 1'b1;

endpackage

`default_nettype wire

@@ rtl/core/blfu_in_if.sv @@
// blfu_in_if: input channel of the lowest-unused-value finder
// valid/ready handshake with kind and value payload; depends on blfu_pkg
`default_nettype none

interface blfu_in_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [blfu_pkg::VAL_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

`default_nettype wire

@@ rtl/core/blfu_out_if.sv @@
// blfu_out_if: result channel of the lowest-unused-value finder
// valid/ready handshake with lowest_unused and all_used; depends on blfu_pkg
`default_nettype none

interface blfu_out_if;
  logic                       valid;
  logic                       ready;
  logic [blfu_pkg::VAL_W-1:0] lowest_unused;
  logic                       all_used;

  modport source (output valid, output lowest_unused, output all_used, input ready);
  modport sink   (input valid, input lowest_unused, input all_used, output ready);
endinterface

`default_nettype wire

@@ rtl/core/blfu_zero_find.sv @@
// blfu_zero_find: lowest clear bit of one bitmap word
// shared compare unit of the scan sequencer; no package dependency
`default_nettype none

module blfu_zero_find #(
  parameter int WORD_BITS = 64
) (
  input  logic [WORD_BITS-1:0]         word,
  output logic                         hit,
  output logic [$clog2(WORD_BITS)-1:0] pos
);

  localparam int BIT_W = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] low_zero;

  // isolate the lowest clear bit: carry of word + 1 stops there
  assign low_zero = ~word & (word + WORD_BITS'(1));
  assign hit      = |(~word);

  // encode the one-hot position
  always_comb begin
    pos = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (low_zero[i]) begin
        pos = pos | BIT_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bitmap_lowest_unused_finder_top.sv @@
// bitmap_lowest_unused_finder_top: presence bitmap with lowest-unused search
// depends on blfu_pkg, blfu_in_if, blfu_out_if and blfu_zero_find
//
// Keeps one presence bit per value of VALUE_BITS bits in a memory of
// ceil(2^VALUE_BITS / WORD_BITS) words (1024 words of 64 bits by default).
// After reset a clearing pass writes zero to one word per cycle, so the block
// takes no item until every word has been cleared. A record item marks
// its value and gives no result; records flow through a three-stage
// read-modify-write pipeline at one item per cycle while idle. A find item
// scans the words upward from zero with one shared compare unit, one word per
// cycle, and returns the lowest clear value, or the top value with all_used
// set when every value has been seen. After a find is taken the input stays
// blocked while the scan runs: it waits for a record still being written,
// reads one word per cycle, checks each word it has read and then loads the
// result register. It ends earlier when a clear bit turns up sooner, and
// lasts longer while the previous result has not been taken. The result
// sits in an output register, so records keep flowing while it waits to be
// taken.
`default_nettype none

module bitmap_lowest_unused_finder_top #(
  parameter int VALUE_BITS = 16,
  parameter int WORD_BITS  = 64
) (
  input logic        clk,
  input logic        rst_n,
  blfu_in_if.sink    in_ch,
  blfu_out_if.source out_ch
);

  localparam int VAL_W = blfu_pkg::VAL_W;
  localparam int SHIFT = blfu_pkg::DIV_SHIFT;
  localparam longint unsigned VAL_RANGE = 64'd1 << VALUE_BITS;
  localparam longint unsigned N_WORDS   = (VAL_RANGE + WORD_BITS - 1) / WORD_BITS;
  localparam int DEPTH  = int'(N_WORDS);
  localparam int IDX_W  = (N_WORDS > 1) ? $clog2(N_WORDS) : 1;
  localparam int BIT_W  = $clog2(WORD_BITS);
  localparam int BASE_W = VALUE_BITS + 1;
  localparam int PROD_W = VAL_W + SHIFT;
  localparam longint unsigned RECIP = ((64'd1 << SHIFT) + WORD_BITS - 1) / WORD_BITS;
  localparam logic [SHIFT-1:0]  RECIP_V  = SHIFT'(RECIP);
  localparam logic [VAL_W-1:0]  VAL_MASK = VAL_W'(VAL_RANGE - 1);
  localparam logic [VAL_W-1:0]  VAL_TOP  = VAL_W'(VAL_RANGE - 1);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(N_WORDS - 1);

  // sequencer states
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_HOLD  = 2'd3;

  logic [1:0]           state_r;
  logic [IDX_W-1:0]     clr_idx_r;

  logic                 in_acc;
  logic [VAL_W-1:0]     in_val;
  logic [PROD_W-1:0]    in_prod;

  // record pipeline
  logic                 a_valid_r;
  logic [VAL_W-1:0]     a_val_r;
  logic [VAL_W-1:0]     a_quo_r;
  logic [VAL_W-1:0]     a_rem;
  logic [IDX_W-1:0]     a_idx;
  logic                 b_valid_r;
  logic [IDX_W-1:0]     b_idx_r;
  logic [BIT_W-1:0]     b_bit_r;
  logic                 wp_valid_r;
  logic [IDX_W-1:0]     wp_idx_r;
  logic [WORD_BITS-1:0] wp_data_r;
  logic [WORD_BITS-1:0] old_word;
  logic [WORD_BITS-1:0] new_word;

  // memory
  logic [WORD_BITS-1:0] mem [0:DEPTH-1];
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;

  // scan
  logic                 scan_rd;
  logic [IDX_W-1:0]     scan_idx_r;
  logic [BASE_W-1:0]    scan_base_r;
  logic                 scan_done_r;
  logic                 chk_valid_r;
  logic                 chk_last_r;
  logic [BASE_W-1:0]    chk_base_r;
  logic                 zf_hit;
  logic [BIT_W-1:0]     zf_pos;
  logic [BASE_W-1:0]    cand;
  logic                 scan_fin;
  logic                 res_all;
  logic [VAL_W-1:0]     res_val;
  logic                 hold_all_r;
  logic [VAL_W-1:0]     hold_val_r;

  // result register
  logic                 out_valid_r;
  logic                 out_all_r;
  logic [VAL_W-1:0]     out_val_r;
  logic                 out_load;

  // input handshake and value split by reciprocal multiply
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_val      = in_ch.value & VAL_MASK;
  assign in_prod     = {{SHIFT{1'b0}}, in_val} * {{VAL_W{1'b0}}, RECIP_V};

  // word index and bit offset of the registered value
  assign a_rem = a_val_r - VAL_W'(a_quo_r * VAL_W'(WORD_BITS));
  assign a_idx = IDX_W'(a_quo_r);

  // merge with the write of the previous cycle that the read missed
  assign old_word = (wp_valid_r && (wp_idx_r == b_idx_r)) ? wp_data_r : rd_data_r;
  assign new_word = old_word | (WORD_BITS'(1) << b_bit_r);

  // scan reads wait until the record pipeline has drained
  assign scan_rd = (state_r == ST_SCAN) && !b_valid_r && !scan_done_r;
  assign rd_en   = a_valid_r || scan_rd;
  assign rd_addr = a_valid_r ? a_idx : scan_idx_r;

  // shared word compare unit
  blfu_zero_find #(
    .WORD_BITS (WORD_BITS)
  ) u_zero_find (
    .word (rd_data_r),
    .hit  (zf_hit),
    .pos  (zf_pos)
  );

  // decide the outcome of the checked word
  assign cand     = chk_base_r + BASE_W'(zf_pos);
  assign scan_fin = (state_r == ST_SCAN) && chk_valid_r && (zf_hit || chk_last_r);
  assign res_all  = !zf_hit || cand[VALUE_BITS];
  assign res_val  = res_all ? VAL_TOP : VAL_W'(cand);

  // result register loads once the previous result has gone
  assign out_load = (state_r == ST_HOLD) && (!out_valid_r || out_ch.ready);

  // bitmap memory: clearing pass, record writes, one read port
  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) begin
      mem[clr_idx_r] <= '0;
    end else if (b_valid_r) begin
      mem[b_idx_r] <= new_word;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    a_val_r    <= in_val;
    a_quo_r    <= in_prod[SHIFT +: VAL_W];
    b_idx_r    <= a_idx;
    b_bit_r    <= a_rem[BIT_W-1:0];
    wp_idx_r   <= b_idx_r;
    wp_data_r  <= new_word;
    chk_base_r <= scan_base_r;
    chk_last_r <= (scan_idx_r == LAST_IDX);
  end

  // sequencer and valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      wp_valid_r  <= 1'b0;
      chk_valid_r <= 1'b0;
      scan_done_r <= 1'b0;
      scan_idx_r  <= '0;
      scan_base_r <= '0;
      out_valid_r <= 1'b0;
      out_all_r   <= 1'b0;
      out_val_r   <= '0;
      hold_all_r  <= 1'b0;
      hold_val_r  <= '0;
    end else begin
      a_valid_r   <= in_acc && (in_ch.kind == blfu_pkg::KIND_RECORD);
      b_valid_r   <= a_valid_r;
      wp_valid_r  <= b_valid_r;
      chk_valid_r <= scan_rd;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_idx_r <= clr_idx_r + IDX_W'(1);
          if (clr_idx_r == LAST_IDX) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc && (in_ch.kind == blfu_pkg::KIND_FIND)) begin
            state_r     <= ST_SCAN;
            scan_idx_r  <= '0;
            scan_base_r <= '0;
            scan_done_r <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (scan_rd) begin
            scan_idx_r  <= scan_idx_r + IDX_W'(1);
            scan_base_r <= scan_base_r + BASE_W'(WORD_BITS);
            scan_done_r <= (scan_idx_r == LAST_IDX);
          end
          if (scan_fin) begin
            hold_all_r <= res_all;
            hold_val_r <= res_val;
            state_r    <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_load) begin
            out_all_r <= hold_all_r;
            out_val_r <= hold_val_r;
            state_r   <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // result channel
  assign out_ch.valid         = out_valid_r;
  assign out_ch.lowest_unused = out_val_r;
  assign out_ch.all_used      = out_all_r;

  // records enter only from idle, so a scan never shares the read port
  a_record_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r |-> (state_r == ST_IDLE))
    else $error("record pipeline active outside idle");

  // nothing but the clearing pass writes the memory while clearing
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (!a_valid_r && !b_valid_r && !scan_rd))
    else $error("memory access during clearing pass");

  // a result appears only after a finished scan
  a_result_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_HOLD))
    else $error("result raised without a finished scan");

endmodule

`default_nettype wire
